@@ hw/rtl/jcsp_pkg.sv @@
// ----------------------------------------------------------------------------
// JSON command stream parser package
// Shared types, codes and constants for the byte-wise command parser.
// ----------------------------------------------------------------------------
package jcsp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_NAME  = 3'd1,
    ST_SEP   = 3'd2,
    ST_VALUE = 3'd3,
    ST_ARRAY = 3'd4,
    ST_CONT  = 3'd5,
    ST_ACONT = 3'd6
  } main_state_e;

  typedef enum logic [1:0] {
    SUB_NONE = 2'd0,
    SUB_NUM  = 2'd1,
    SUB_BOOL = 2'd2,
    SUB_STR  = 2'd3
  } sub_state_e;

  typedef enum logic [1:0] {
    CMD_NIL  = 2'd0,
    CMD_GET  = 2'd1,
    CMD_SET  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    PRM_NONE  = 2'd0,
    PRM_PORT  = 2'd1,
    PRM_VALUE = 2'd2,
    PRM_MODE  = 2'd3
  } prm_e;

  localparam logic [2:0] PK_NONE = 3'd0;
  localparam logic [2:0] PK_IN   = 3'd1;
  localparam logic [2:0] PK_OUT  = 3'd2;
  localparam logic [2:0] PK_CNT  = 3'd3;
  localparam logic [2:0] PK_MOT  = 3'd4;
  localparam logic [2:0] PK_LED  = 3'd5;

  localparam logic [4:0] ERR_STATE      = 5'd0;
  localparam logic [4:0] ERR_NEED_OBJ   = 5'd1;
  localparam logic [4:0] ERR_NEED_STR   = 5'd2;
  localparam logic [4:0] ERR_EXP_COLON  = 5'd3;
  localparam logic [4:0] ERR_END_STR    = 5'd5;
  localparam logic [4:0] ERR_CONT       = 5'd6;
  localparam logic [4:0] ERR_VALUE      = 5'd7;
  localparam logic [4:0] ERR_ACONT      = 5'd8;
  localparam logic [4:0] ERR_CMD        = 5'd9;
  localparam logic [4:0] ERR_PARAM      = 5'd10;
  localparam logic [4:0] ERR_TYPE       = 5'd11;
  localparam logic [4:0] ERR_PORT       = 5'd12;
  localparam logic [4:0] ERR_MODE       = 5'd13;
  localparam logic [4:0] ERR_MODE_PORT  = 5'd14;
  localparam logic [4:0] ERR_NO_CMD     = 5'd15;
  localparam logic [4:0] ERR_GET_REQ    = 5'd16;

  localparam logic [7:0] ESC_BYTE = 8'h1b;

  // Fields of a pending or emitted command.
  typedef struct packed {
    logic [1:0]  request;
    logic [2:0]  port_kind;
    logic [2:0]  port_number;
    logic [3:0]  mode_code;
    logic        value_present;
    logic        value_is_bool;
    logic [15:0] value_word;
  } fields_t;

  typedef struct packed {
    logic        result_kind;
    logic [4:0]  error_code;
    logic        command;
    fields_t     f;
  } result_t;

  // Keyword matching on up to 10 buffered characters: the keywords are short.
  localparam int KW_MAX = 10;
  typedef logic [KW_MAX*8-1:0] kw_t;

  // Packs a keyword, first character in the low byte, zero filled.
  function automatic kw_t kw(input string s);
    kw_t r;
    r = '0;
    for (int i = 0; i < s.len() && i < KW_MAX; i++) r[i*8 +: 8] = s[i];
    return r;
  endfunction

endpackage

@@ hw/rtl/jcsp_match.sv @@
// ----------------------------------------------------------------------------
// JSON command stream parser keyword matcher
// Compares the text buffer in parallel against the fixed keywords.
// ----------------------------------------------------------------------------
module jcsp_match #(
  parameter int TextChars = 16,
  parameter int LenW      = 5
) (
  input  logic [TextChars*8-1:0] buf_i,
  input  logic [LenW-1:0]        len_i,
  output logic [11:0]            prefix_o,
  output logic [4:0]             equal_o
);
  import jcsp_pkg::*;

  // Prefix keywords: devices, version, led, high, low, open, voltage, resistance,
  // switch, left, right, brake, off. Exact names: set, get, port, value, mode.

  function automatic logic pre(input logic [TextChars*8-1:0] b,
                               input logic [LenW-1:0] n, input kw_t k);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < TextChars; i++) begin
      if (i < n) begin
        if (i >= KW_MAX) ok = 1'b0;
        else if (k[i*8 +: 8] == 8'd0 || b[i*8 +: 8] != k[i*8 +: 8]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic logic eqk(input logic [TextChars*8-1:0] b,
                               input logic [LenW-1:0] n, input kw_t k);
    logic ok;
    ok = pre(b, n, k);
    if (n < LenW'(KW_MAX)) begin
      if (k[n*8 +: 8] != 8'd0) ok = 1'b0;
    end
    return ok;
  endfunction

  always_comb begin
    prefix_o = '0;
    prefix_o[0]  = pre(buf_i, len_i, kw("devices"));
    prefix_o[1]  = pre(buf_i, len_i, kw("version"));
    prefix_o[2]  = pre(buf_i, len_i, kw("led"));
    prefix_o[3]  = pre(buf_i, len_i, kw("high"));
    prefix_o[4]  = pre(buf_i, len_i, kw("low"));
    prefix_o[5]  = pre(buf_i, len_i, kw("open")) | pre(buf_i, len_i, kw("off"));
    prefix_o[6]  = pre(buf_i, len_i, kw("voltage"));
    prefix_o[7]  = pre(buf_i, len_i, kw("resistance"));
    prefix_o[8]  = pre(buf_i, len_i, kw("switch"));
    prefix_o[9]  = pre(buf_i, len_i, kw("left"));
    prefix_o[10] = pre(buf_i, len_i, kw("right"));
    prefix_o[11] = pre(buf_i, len_i, kw("brake"));
    equal_o[0] = eqk(buf_i, len_i, kw("set"));
    equal_o[1] = eqk(buf_i, len_i, kw("get"));
    equal_o[2] = eqk(buf_i, len_i, kw("port"));
    equal_o[3] = eqk(buf_i, len_i, kw("value"));
    equal_o[4] = eqk(buf_i, len_i, kw("mode"));
  end

endmodule

@@ hw/rtl/jcsp_core.sv @@
// ----------------------------------------------------------------------------
// JSON command stream parser core
// Holds the parser state and decides, per byte, the next state and result.
// ----------------------------------------------------------------------------
module jcsp_core #(
  parameter int TextChars = 16,
  parameter int MaxNest   = 15,
  parameter int NestW     = 4,
  parameter int LenW      = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  output logic              emit_o,
  output jcsp_pkg::result_t res_o
);
  import jcsp_pkg::*;

  main_state_e main_q, main_d;
  sub_state_e  sub_q, sub_d;
  logic [NestW-1:0] nest_q, nest_d;
  logic [TextChars*8-1:0] buf_q, buf_d;
  logic [LenW-1:0] len_q, len_d;
  logic [15:0] num_q, num_d;
  logic bool_q, bool_d;
  cmd_e cmd_q, cmd_d;
  prm_e prm_q, prm_d;
  fields_t fld_q, fld_d;

  logic [11:0] pfx;
  logic [4:0]  eqv;

  jcsp_match #(.TextChars(TextChars), .LenW(LenW)) u_match (
    .buf_i(buf_q), .len_i(len_q), .prefix_o(pfx), .equal_o(eqv)
  );

  logic [7:0] c, lc, first;
  logic digit, alpha, ws;
  logic [2:0] idx;
  logic idx_ok8, idx_ok4;
  logic [15:0] num_mul;

  assign c     = byte_i;
  assign digit = (c >= "0") && (c <= "9");
  assign alpha = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  assign ws    = (c == " ") || (c == 8'd10) || (c == 8'd13) || (c == 8'd9);
  assign lc    = ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
  assign first = buf_q[7:0];
  assign idx   = buf_q[10:8] - 3'd1;
  assign idx_ok8 = (buf_q[15:8] >= "1") && (buf_q[15:8] <= "8");
  assign idx_ok4 = (buf_q[15:8] >= "1") && (buf_q[15:8] <= "4");
  assign num_mul = (num_q << 3) + (num_q << 1) + 16'(c - "0");

  always_comb begin
    sub_state_e kind;
    logic consumed, err, done;
    logic [4:0] code;
    logic len2;
    fields_t f;
    main_d = main_q; sub_d = sub_q; nest_d = nest_q; buf_d = buf_q;
    len_d = len_q; num_d = num_q; bool_d = bool_q; cmd_d = cmd_q;
    prm_d = prm_q; fld_d = fld_q;
    kind = SUB_NONE; consumed = 1'b0; err = 1'b0; done = 1'b0;
    code = ERR_STATE; len2 = (len_q == LenW'(2));
    f = fld_q;
    emit_o = 1'b0;
    res_o = '0;
    if (!step_i || (sub_q != SUB_STR && ws)) begin
      // nothing to do
    end else if (c == 8'd0 || c == ESC_BYTE) begin
      main_d = ST_IDLE; sub_d = SUB_NONE; nest_d = '0;
      cmd_d = CMD_NIL; prm_d = PRM_NONE; fld_d = '0;
    end else begin
      unique case (sub_q)
        SUB_NUM: if (digit) num_d = num_mul; else kind = SUB_NUM;
        SUB_BOOL: if (!alpha) kind = SUB_BOOL;
        SUB_STR: begin
          if (c == "\"") begin
            kind = SUB_STR; consumed = 1'b1;
          end else if (len_q < LenW'(TextChars - 1)) begin
            buf_d[len_q*8 +: 8] = lc;
            len_d = len_q + 1'b1;
          end
        end
        default: ;
      endcase
      if (kind != SUB_NONE) begin
        if (main_q == ST_NAME) begin
          if (nest_q == '0) begin
            if (eqv[0]) cmd_d = CMD_SET;
            else if (eqv[1]) cmd_d = CMD_GET;
            else begin err = 1'b1; code = ERR_CMD; end
          end else if (nest_q == NestW'(1)) begin
            if (eqv[2]) prm_d = PRM_PORT;
            else if (eqv[3]) prm_d = PRM_VALUE;
            else if (eqv[4]) prm_d = PRM_MODE;
            else begin err = 1'b1; code = ERR_PARAM; end
          end
        end else if (main_q == ST_VALUE) begin
          if (cmd_q == CMD_GET) begin
            if (nest_q == NestW'(1) && prm_q == PRM_PORT) begin
              f.port_kind = PK_NONE; f.port_number = '0;
              if (kind != SUB_STR || !len2) begin err = 1'b1; code = ERR_TYPE; end
              else if (first == "i" && idx_ok8) begin
                f.port_kind = PK_IN; f.port_number = idx;
              end else if (first == "c" && idx_ok4) begin
                f.port_kind = PK_CNT; f.port_number = idx;
              end else begin err = 1'b1; code = ERR_PORT; end
            end
            if (nest_q == '0) begin
              if (kind != SUB_STR) begin err = 1'b1; code = ERR_TYPE; end
              else if (pfx[0]) f.request = 2'd1;
              else if (pfx[1]) f.request = 2'd2;
              else begin err = 1'b1; code = ERR_GET_REQ; end
            end
          end else if (cmd_q == CMD_SET && nest_q == NestW'(1)) begin
            if (prm_q == PRM_PORT) begin
              f.port_kind = PK_NONE; f.port_number = '0;
              if (kind != SUB_STR) begin err = 1'b1; code = ERR_TYPE; end
              else if (pfx[2]) f.port_kind = PK_LED;
              else if (!len2) begin err = 1'b1; code = ERR_PORT; end
              else if (first == "i" && idx_ok8) begin
                f.port_kind = PK_IN; f.port_number = idx;
              end else if (first == "o" && idx_ok8) begin
                f.port_kind = PK_OUT; f.port_number = idx;
              end else if (first == "c" && idx_ok4) begin
                f.port_kind = PK_CNT; f.port_number = idx;
              end else if (first == "m" && idx_ok4) begin
                f.port_kind = PK_MOT; f.port_number = idx;
              end else begin err = 1'b1; code = ERR_PORT; end
            end else if (prm_q == PRM_MODE) begin
              if (kind != SUB_STR) begin err = 1'b1; code = ERR_TYPE; end
              else begin
                err = 1'b1; code = ERR_MODE;
                for (int m = 8; m >= 0; m--) begin
                  if (pfx[3+m]) begin f.mode_code = 4'(m + 1); err = 1'b0; end
                end
              end
            end else if (prm_q == PRM_VALUE) begin
              if (kind == SUB_NUM) begin
                f.value_present = 1'b1; f.value_is_bool = 1'b0; f.value_word = num_q;
              end else if (kind == SUB_BOOL) begin
                f.value_present = 1'b1; f.value_is_bool = 1'b1;
                f.value_word = {15'd0, bool_q};
              end else begin err = 1'b1; code = ERR_TYPE; end
            end
          end
        end
        if (!err) begin
          fld_d = f;
          sub_d = SUB_NONE;
          unique case (main_q)
            ST_NAME:  main_d = ST_SEP;
            ST_VALUE: main_d = ST_CONT;
            ST_ARRAY: main_d = ST_ACONT;
            default: begin err = 1'b1; code = ERR_END_STR; end
          endcase
        end
      end
      if (!err && (sub_d == SUB_NONE) && !consumed) begin
        unique case (main_d)
          ST_IDLE: if (c == "{") main_d = ST_NAME; else begin err = 1'b1; code = ERR_NEED_OBJ; end
          ST_NAME: begin
            if (c == "}") begin
              cmd_d = CMD_NIL; prm_d = PRM_NONE; fld_d = '0; main_d = ST_IDLE;
            end else if (c == "\"") begin
              sub_d = SUB_STR; len_d = '0;
            end else begin err = 1'b1; code = ERR_NEED_STR; end
          end
          ST_SEP: if (c == ":") main_d = ST_VALUE; else begin err = 1'b1; code = ERR_EXP_COLON; end
          ST_VALUE, ST_ARRAY: begin
            if (c == "\"") begin
              sub_d = SUB_STR; len_d = '0;
            end else if (digit) begin
              sub_d = SUB_NUM; num_d = {12'd0, c[3:0]};
            end else if (c == "t" || c == "T" || c == "f" || c == "F") begin
              sub_d = SUB_BOOL; bool_d = (c == "t" || c == "T");
            end else if (c == "[" && main_d == ST_VALUE) begin
              main_d = ST_ARRAY;
            end else if (c == "{" && nest_q < NestW'(MaxNest)) begin
              nest_d = nest_q + 1'b1; main_d = ST_NAME;
            end else begin err = 1'b1; code = ERR_VALUE; end
          end
          ST_CONT: begin
            if (c == "}") begin
              if (nest_q != '0) nest_d = nest_q - 1'b1;
              else done = 1'b1;
            end else if (c == ",") main_d = ST_NAME;
            else begin err = 1'b1; code = ERR_CONT; end
          end
          ST_ACONT: begin
            if (c == "]") main_d = ST_CONT;
            else if (c == ",") main_d = ST_ARRAY;
            else begin err = 1'b1; code = ERR_ACONT; end
          end
          default: begin err = 1'b1; code = ERR_STATE; end
        endcase
      end
      if (done) begin
        if (cmd_q == CMD_NIL) begin err = 1'b1; code = ERR_NO_CMD; end
        else if (cmd_q == CMD_SET && fld_q.mode_code != 4'd0 &&
                 ((fld_q.port_kind == PK_OUT && fld_q.mode_code > 4'd3) ||
                  (fld_q.port_kind == PK_IN &&
                   (fld_q.mode_code < 4'd4 || fld_q.mode_code > 4'd6)) ||
                  (fld_q.port_kind == PK_MOT && fld_q.mode_code != 4'd3 &&
                   fld_q.mode_code < 4'd7))) begin
          err = 1'b1; code = ERR_MODE_PORT;
        end else begin
          emit_o = 1'b1;
          res_o.command = (cmd_q == CMD_SET);
          res_o.f = fld_q;
          if (fld_q.port_kind == PK_NONE || fld_q.port_kind == PK_LED)
            res_o.f.port_number = '0;
          cmd_d = CMD_NIL; prm_d = PRM_NONE; fld_d = '0; main_d = ST_IDLE;
        end
      end
      if (err) begin
        emit_o = 1'b1;
        res_o = '0;
        res_o.result_kind = 1'b1;
        res_o.error_code = code;
        main_d = ST_IDLE; sub_d = SUB_NONE; nest_d = '0;
        cmd_d = CMD_NIL; prm_d = PRM_NONE; fld_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_q <= ST_IDLE; sub_q <= SUB_NONE; nest_q <= '0; len_q <= '0;
      num_q <= '0; bool_q <= 1'b0; cmd_q <= CMD_NIL; prm_q <= PRM_NONE;
      fld_q <= '0;
    end else begin
      main_q <= main_d; sub_q <= sub_d; nest_q <= nest_d; len_q <= len_d;
      num_q <= num_d; bool_q <= bool_d; cmd_q <= cmd_d; prm_q <= prm_d;
      fld_q <= fld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  // The string length never passes the buffer limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(TextChars - 1)) else $error("text length overflow");
  // Nesting stays within the limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    nest_q <= NestW'(MaxNest)) else $error("nest level overflow");
  // Every result leaves the parser idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |=> (main_q == ST_IDLE && sub_q == SUB_NONE)) else $error("not idle after result");

endmodule

@@ hw/rtl/json_command_stream_parser_top.sv @@
// ----------------------------------------------------------------------------
// JSON command stream parser top level
// Parses a byte stream of JSON commands and emits decoded commands or errors.
// ----------------------------------------------------------------------------
//  channel | direction | tdata fields (low bit up)
//  s_axis  | in        | byte_in[7:0]
//  m_axis  | out       | result_kind, error_code, command, request, port_kind,
//          |           | port_number, mode_code, value_present, value_is_bool,
//          |           | value_word (37 bits, zero filled to 40)
// One byte is taken per cycle unless the output stalls; its result, if any, appears in
// the output register in the next cycle, set by the single-pass parser logic.
// rst_ni clears the parser to idle, asynchronously.
// A stalled output stops input only while the output register is full and not
// being drained.
module json_command_stream_parser_top #(
  parameter int TEXT_CHARS = 16,
  parameter int MAX_NEST   = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // byte_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // result fields as listed above
);
  import jcsp_pkg::*;

  localparam int NestW = $clog2(MAX_NEST + 1);
  localparam int LenW  = $clog2(TEXT_CHARS);

  logic    step, emit;
  result_t res;
  logic    ovalid_q;
  logic [36:0] odata_q;

  assign s_axis_tready_o = !ovalid_q || m_axis_tready_i;
  assign step = s_axis_tvalid_i && s_axis_tready_o;

  jcsp_core #(.TextChars(TEXT_CHARS), .MaxNest(MAX_NEST), .NestW(NestW), .LenW(LenW))
    u_core (.clk_i, .rst_ni, .step_i(step), .byte_i(s_axis_tdata_i),
            .emit_o(emit), .res_o(res));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      ovalid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && emit) begin
      odata_q <= {res.f.value_word, res.f.value_is_bool, res.f.value_present,
                  res.f.mode_code, res.f.port_number, res.f.port_kind,
                  res.f.request, res.command, res.error_code, res.result_kind};
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {3'd0, odata_q};

  // A held result is not overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !m_axis_tready_i) |=> (ovalid_q && $stable(odata_q)))
    else $error("held result lost");
  // Input is refused only while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> ovalid_q) else $error("spurious stall");
  // A result leaves the core only on an accepted byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> step) else $error("result without byte");

endmodule
